### rtl/core/spq_pkg.sv
// shared constants, types and helpers of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRIO_W   = 8;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
  } entry_t;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

  typedef struct packed {
    logic idle;
    cnt_t count;
  } eng_stat_t;

  // ring position of logical slot off, counted from base
  function automatic idx_t ring_idx(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/spq_ifs.sv
// valid/ready channel interfaces for the queue request and response words
`timescale 1ns / 1ps

interface spq_cmd_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] item_value;
  logic [7:0]         priority_req;

  modport source (output valid, action, item_value, priority_req, input ready);
  modport sink   (input valid, action, item_value, priority_req, output ready);
endinterface

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [4:0]         occupancy;

  modport source (output valid, result_value, status, occupancy, input ready);
  modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

### rtl/core/spq_engine.sv
// sequencer and entry memory: sorted ring of entries, insertion by walking from the tail
`timescale 1ns / 1ps

module spq_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spq_pkg::cmd_t     cmd,
  output spq_pkg::eng_stat_t stat,
  output logic              res_valid,
  output spq_pkg::res_t     res,
  input  logic              res_ready
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  entry_t mem [CAPACITY];
  entry_t rdata;

  logic [2:0] state, state_next;
  idx_t       head, head_next;
  cnt_t       count, count_next;
  idx_t       idx, idx_next;
  cmd_t       cur, cur_next;
  logic signed [VAL_W-1:0] res_value, res_value_next;
  logic [STAT_W-1:0]       res_status, res_status_next;

  logic   re, we;
  idx_t   raddr, waddr;
  entry_t wdata;
  entry_t new_entry;

  assign new_entry = '{value: cur.value, prio: cur.prio};

  // reads always sit below the slot being written, so no forwarding is needed
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    cur_next        = cur;
    res_value_next  = res_value;
    res_status_next = res_status;
    re              = 1'b0;
    raddr           = head;
    we              = 1'b0;
    waddr           = head;
    wdata           = new_entry;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next       = cmd;
          res_value_next = '0;
          if (cmd.action == ACT_DEQ) begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              re         = 1'b1;
              raddr      = head;
              state_next = S_DEQ;
            end
          end else if (count == cnt_t'(CAPACITY)) begin
            res_status_next = ST_FULL;
            state_next      = S_DONE;
          end else if (count == '0) begin
            we              = 1'b1;
            waddr           = head;
            wdata           = '{value: cmd.value, prio: cmd.prio};
            count_next      = count + 1'b1;
            res_status_next = ST_ENQUEUED;
            state_next      = S_DONE;
          end else begin
            idx_next   = idx_t'(count - 1'b1);
            re         = 1'b1;
            raddr      = ring_idx(head, idx_t'(count - 1'b1));
            state_next = S_SCAN;
          end
        end
      end
      S_DEQ: begin
        res_value_next  = rdata.value;
        res_status_next = ST_DEQUEUED;
        head_next       = ring_idx(head, idx_t'(1));
        count_next      = count - 1'b1;
        state_next      = S_DONE;
      end
      S_SCAN: begin
        we    = 1'b1;
        waddr = ring_idx(head, idx + 1'b1);
        if (rdata.prio >= cur.prio) begin
          // new entry goes behind this one
          wdata           = new_entry;
          count_next      = count + 1'b1;
          res_status_next = ST_ENQUEUED;
          state_next      = S_DONE;
        end else begin
          wdata = rdata;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            idx_next = idx - 1'b1;
            re       = 1'b1;
            raddr    = ring_idx(head, idx - 1'b1);
          end
        end
      end
      S_PLACE: begin
        we              = 1'b1;
        waddr           = head;
        wdata           = new_entry;
        count_next      = count + 1'b1;
        res_status_next = ST_ENQUEUED;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    idx        <= idx_next;
    cur        <= cur_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  assign stat.idle  = (state == S_IDLE);
  assign stat.count = count;
  assign res_valid  = (state == S_DONE);
  assign res.value     = res_value;
  assign res.status    = res_status;
  assign res.occupancy = OCC_W'(count);

endmodule

### rtl/core/sorted_priority_queue_unit.sv
// sorted priority queue: request handshake, sequencer and registered response word
// from request accept to response valid: dequeue reads the head entry, then registers it;
//   enqueue walks past lower-priority entries; empty enqueues and refusals answer directly
// one request at a time, the next taken after the response word is registered;
//   the insertion walk (one memory read and one write a cycle) sets the enqueue time
// synchronous reset empties the queue at once; entry memory contents are left as they are
`timescale 1ns / 1ps

module sorted_priority_queue_unit (
  input  logic      clk,
  input  logic      rst,
  spq_cmd_if.sink   cmd,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  eng_stat_t stat;
  cmd_t      cmd_word;
  res_t      eng_res;
  res_t      out_word;
  logic      start;
  logic      eng_res_valid;
  logic      res_ready;
  logic      out_valid;

  assign cmd.ready = stat.idle;
  assign start     = cmd.valid && cmd.ready;
  assign cmd_word  = '{action: cmd.action, value: cmd.item_value, prio: cmd.priority_req};

  spq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd_word),
    .stat      (stat),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_ready (res_ready)
  );

  // output word register frees the engine as soon as the word is parked
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= eng_res_valid;
    end
    if (res_ready && eng_res_valid) begin
      out_word <= eng_res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_word.value;
  assign rsp.status       = out_word.status;
  assign rsp.occupancy    = out_word.occupancy;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    start |=> !cmd.ready)
    else $error("request taken while another is in progress");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    eng_res_valid && eng_res.status == ST_FULL |-> stat.count == cnt_t'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    eng_res_valid && eng_res.status == ST_EMPTY |-> stat.count == '0 && eng_res.value == '0)
    else $error("empty reported with entries held");

endmodule

### tb/sv/sorted_priority_queue_unit_tb.sv
// self-checking testbench of the sorted priority queue unit
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int RANDOM_WORDS = 1080;
  localparam int CALM_WORDS   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  // shadow copy of the queue contents and the responses still owed
  class spq_shadow;
    entry_t      held[$];
    res_t        due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic act, logic signed [VAL_W-1:0] val,
                               logic [PRIO_W-1:0] pr);
      res_t   r;
      entry_t e;
      int     pos;
      r.value = '0;
      if (act == ACT_ENQ) begin
        if (held.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind all entries of equal or higher priority
          pos = 0;
          while (pos < held.size() && held[pos].prio >= pr) pos++;
          e.value = val;
          e.prio  = pr;
          held.insert(pos, e);
          r.status = ST_ENQUEUED;
        end
      end else if (held.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value  = held[0].value;
        r.status = ST_DEQUEUED;
        void'(held.pop_front());
      end
      r.occupancy = OCC_W'(held.size());
      due.push_back(r);
    endfunction

    function void report(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t mismatch (%s): expected value %0d status %0d occupancy %0d",
                 $realtime, what, want.value, want.status, want.occupancy);
        $display("  got value %0d status %0d occupancy %0d",
                 got.value, got.status, got.occupancy);
      end
    endfunction

    function void check_response(res_t got);
      res_t want;
      if (due.size() == 0) begin
        report("word with nothing outstanding", '0, got);
        return;
      end
      want = due.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.occupancy !== want.occupancy) begin
        report("response word", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned cycle_count = 0;
  bit calm = 1'b0;
  bit gaps_on = 1'b1;
  spq_shadow shadow = new();

  spq_cmd_if cmd_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_priority_queue_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      shadow.check_response({rsp_ch.result_value, rsp_ch.status, rsp_ch.occupancy});
    end
  end

  // response side back-pressure in bursts
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // present one word, hold it until taken, then maybe go quiet for a burst
  task automatic send_word(logic act, logic signed [VAL_W-1:0] val, logic [PRIO_W-1:0] pr);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.action       <= act;
    cmd_ch.item_value   <= val;
    cmd_ch.priority_req <= pr;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    shadow.note_request(act, val, pr);
    if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid        <= 1'b0;
      cmd_ch.item_value   <= $urandom;
      cmd_ch.priority_req <= PRIO_W'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_responses();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                      n;
    int unsigned             enq_pct;
    int unsigned             prio_mode;
    logic                    act;
    logic signed [VAL_W-1:0] val;
    logic [PRIO_W-1:0]       pr;
    logic [PRIO_W-1:0]       fill_prio[15];

    fill_prio = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd1, 8'd254, 8'd128, 8'd0,
                  8'd255, 8'd7, 8'd7, 8'd200, 8'd64, 8'd3, 8'd128};
    enq_pct   = 50;
    prio_mode = 1;
    rst = 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.action       <= ACT_ENQ;
    cmd_ch.item_value   <= '0;
    cmd_ch.priority_req <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // dequeue from empty, with junk in the unused fields
    send_word(ACT_DEQ, 32'sh5a5a_a5a5, 8'hff);
    send_word(ACT_ENQ, 32'sh7fff_ffff, 8'd0);
    send_word(ACT_ENQ, 32'sh8000_0000, 8'd255);
    // equal priority must leave in arrival order
    send_word(ACT_ENQ, -32'sd1, 8'd255);
    send_word(ACT_DEQ, '0, '0);
    send_word(ACT_DEQ, '0, '0);
    // fill to capacity, then one more is refused
    for (n = 0; n < 15; n++) send_word(ACT_ENQ, 100 + n - 7, fill_prio[n]);
    send_word(ACT_ENQ, 32'sd5, 8'd255);
    send_word(ACT_DEQ, 32'shffff_ffff, 8'hff);

    drain_responses();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 4))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 65;
          3: enq_pct = 85;
          default: enq_pct = 100;
        endcase
        prio_mode = $urandom_range(0, 3);
        gaps_on   = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_WORDS / 2) drain_responses();
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;

      act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      case ($urandom_range(0, 9))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = '0;
        3: val = -32'sd1;
        default: val = $urandom;
      endcase
      case (prio_mode)
        0: pr = PRIO_W'($urandom_range(0, 3));
        1: pr = PRIO_W'($urandom_range(0, 255));
        2: pr = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        default: pr = PRIO_W'($urandom_range(120, 135));
      endcase
      send_word(act, val, pr);
    end

    cmd_ch.valid <= 1'b0;
    while (shadow.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.due.size() == 0) begin
      $display("PASS sorted_priority_queue_unit");
    end else begin
      $display("FAIL sorted_priority_queue_unit");
    end
    $finish;
  end

endmodule
